@@ rtl/spq_pkg.sv @@
package spq_pkg;

    typedef logic       t_func;
    typedef logic [1:0] t_status;

    localparam t_func FN_ENQ = 1'b0;
    localparam t_func FN_DEQ = 1'b1;

    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_FULL  = 2'd1;
    localparam t_status ST_EMPTY = 2'd2;

endpackage

@@ rtl/spq_req_if.sv @@
interface spq_req_if
    import spq_pkg::*;
#(
    parameter int TAG_BITS  = 16,
    parameter int PRIO_BITS = 16
);
    logic                 valid;
    logic                 ready;
    t_func                func;
    logic [TAG_BITS-1:0]  item_tag;
    logic [PRIO_BITS-1:0] item_priority;

    modport source (output valid, output func, output item_tag, output item_priority,
                    input ready);
    modport sink   (input valid, input func, input item_tag, input item_priority,
                    output ready);
endinterface

@@ rtl/spq_rsp_if.sv @@
interface spq_rsp_if
    import spq_pkg::*;
#(
    parameter int TAG_BITS  = 16,
    parameter int PRIO_BITS = 16,
    parameter int CNT_BITS  = 5
);
    logic                 valid;
    logic                 ready;
    t_status              status;
    logic [TAG_BITS-1:0]  removed_tag;
    logic [PRIO_BITS-1:0] removed_priority;
    logic [TAG_BITS-1:0]  head_tag;
    logic [PRIO_BITS-1:0] head_priority;
    logic [CNT_BITS-1:0]  entry_count;

    modport source (output valid, output status, output removed_tag,
                    output removed_priority, output head_tag, output head_priority,
                    output entry_count, input ready);
    modport sink   (input valid, input status, input removed_tag,
                    input removed_priority, input head_tag, input head_priority,
                    input entry_count, output ready);
endinterface

@@ rtl/spq_mem.sv @@
module spq_mem #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/sorted_min_priority_queue_top.sv @@
// Sorted min-priority queue of DEPTH entries held in a single-port-write,
// single-port-read memory, with the entries kept in priority order.
// Requests arrive on i_req: func selects enqueue or dequeue of the head, and an
// enqueue carries a tag and a priority. Each request yields exactly one
// transaction on o_rsp with a status, the removed entry on a dequeue, and the
// head and entry count after the operation.
// The block takes one request at a time. An enqueue walks from the tail towards
// the head, one stored entry per cycle through the one priority comparator,
// moving each larger entry up a slot. A dequeue moves every remaining entry
// down a slot, one per cycle. Full and empty errors go straight to the
// response without touching the memory.
// The response is held in an output register, so a stalled receiver holds the
// last transaction while the next request is worked on; the block then waits
// with that result until o_rsp is free, and i_req.ready stays low meanwhile.
// Reset empties the queue and drops any pending response; no clearing pass is
// needed, as only slots below the count are ever read.
module sorted_min_priority_queue_top
    import spq_pkg::*;
#(
    parameter int DEPTH     = 16,
    parameter int PRIO_BITS = 16,
    parameter int TAG_BITS  = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    spq_req_if.sink    i_req,
    spq_rsp_if.source  o_rsp
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int DW = TAG_BITS + PRIO_BITS;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CMP   = 3'd1;
    localparam logic [2:0] S_INS   = 3'd2;
    localparam logic [2:0] S_SHIFT = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]           r_state,    n_state;
    logic [TAG_BITS-1:0]  r_tag,      n_tag;
    logic [PRIO_BITS-1:0] r_prio,     n_prio;
    logic [AW-1:0]        r_idx,      n_idx;
    logic [CW-1:0]        r_count,    n_count;
    logic [TAG_BITS-1:0]  r_head_tag, n_head_tag;
    logic [PRIO_BITS-1:0] r_head_prio, n_head_prio;
    t_status              r_status,   n_status;
    logic [TAG_BITS-1:0]  r_rem_tag,  n_rem_tag;
    logic [PRIO_BITS-1:0] r_rem_prio, n_rem_prio;
    logic                 r_out_valid, n_out_valid;
    logic                 w_load;

    t_status              r_o_status;
    logic [TAG_BITS-1:0]  r_o_rem_tag;
    logic [PRIO_BITS-1:0] r_o_rem_prio;
    logic [TAG_BITS-1:0]  r_o_head_tag;
    logic [PRIO_BITS-1:0] r_o_head_prio;
    logic [CW-1:0]        r_o_count;

    logic                 w_we;
    logic [AW-1:0]        w_waddr;
    logic [DW-1:0]        w_wdata;
    logic [AW-1:0]        w_raddr;
    logic [DW-1:0]        w_rdata;
    logic [TAG_BITS-1:0]  w_rd_tag;
    logic [PRIO_BITS-1:0] w_rd_prio;
    logic                 w_move;
    logic [CW-1:0]        w_last;

    spq_mem #(
        .DEPTH (DEPTH),
        .WIDTH (DW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_rd_tag  = w_rdata[DW-1:PRIO_BITS];
    assign w_rd_prio = w_rdata[PRIO_BITS-1:0];
    assign w_move    = w_rd_prio > r_prio;
    assign w_last    = r_count - CW'(1);
    assign w_load    = (r_state == S_DONE) && (!r_out_valid || o_rsp.ready);

    always_comb begin
        n_state     = r_state;
        n_tag       = r_tag;
        n_prio      = r_prio;
        n_idx       = r_idx;
        n_count     = r_count;
        n_head_tag  = r_head_tag;
        n_head_prio = r_head_prio;
        n_status    = r_status;
        n_rem_tag   = r_rem_tag;
        n_rem_prio  = r_rem_prio;
        n_out_valid = r_out_valid && !o_rsp.ready;
        w_we        = 1'b0;
        w_waddr     = r_idx;
        w_wdata     = {r_tag, r_prio};
        w_raddr     = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_tag      = i_req.item_tag;
                    n_prio     = i_req.item_priority;
                    n_status   = ST_OK;
                    n_rem_tag  = '0;
                    n_rem_prio = '0;
                    if (i_req.func == FN_ENQ) begin
                        if (r_count == CW'(DEPTH)) begin
                            n_status = ST_FULL;
                            n_state  = S_DONE;
                        end else if (r_count == '0) begin
                            n_idx   = '0;
                            n_state = S_INS;
                        end else begin
                            n_idx   = r_count[AW-1:0];
                            w_raddr = r_count[AW-1:0] - AW'(1);
                            n_state = S_CMP;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_status = ST_EMPTY;
                            n_state  = S_DONE;
                        end else begin
                            n_rem_tag  = r_head_tag;
                            n_rem_prio = r_head_prio;
                            if (r_count == CW'(1)) begin
                                n_head_tag  = '0;
                                n_head_prio = '0;
                                n_count     = '0;
                                n_state     = S_DONE;
                            end else begin
                                n_idx   = AW'(1);
                                w_raddr = AW'(1);
                                n_state = S_SHIFT;
                            end
                        end
                    end
                end
            end
            S_CMP: begin
                if (w_move) begin
                    w_we    = 1'b1;
                    w_wdata = w_rdata;
                    if (r_idx == AW'(1)) begin
                        n_idx   = '0;
                        n_state = S_INS;
                    end else begin
                        w_raddr = r_idx - AW'(2);
                        n_idx   = r_idx - AW'(1);
                    end
                end else begin
                    n_state = S_INS;
                end
            end
            S_INS: begin
                w_we    = 1'b1;
                n_count = r_count + CW'(1);
                if (r_idx == '0) begin
                    n_head_tag  = r_tag;
                    n_head_prio = r_prio;
                end
                n_state = S_DONE;
            end
            S_SHIFT: begin
                w_we    = 1'b1;
                w_waddr = r_idx - AW'(1);
                w_wdata = w_rdata;
                if (r_idx == AW'(1)) begin
                    n_head_tag  = w_rd_tag;
                    n_head_prio = w_rd_prio;
                end
                if (CW'(r_idx) == w_last) begin
                    n_count = w_last;
                    n_state = S_DONE;
                end else begin
                    n_idx   = r_idx + AW'(1);
                    w_raddr = r_idx + AW'(1);
                end
            end
            S_DONE: begin
                if (w_load) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_head_tag  <= '0;
            r_head_prio <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_head_tag  <= n_head_tag;
            r_head_prio <= n_head_prio;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tag      <= n_tag;
        r_prio     <= n_prio;
        r_idx      <= n_idx;
        r_status   <= n_status;
        r_rem_tag  <= n_rem_tag;
        r_rem_prio <= n_rem_prio;
        if (w_load) begin
            r_o_status    <= r_status;
            r_o_rem_tag   <= r_rem_tag;
            r_o_rem_prio  <= r_rem_prio;
            r_o_head_tag  <= r_head_tag;
            r_o_head_prio <= r_head_prio;
            r_o_count     <= r_count;
        end
    end

    assign i_req.ready            = (r_state == S_IDLE);
    assign o_rsp.valid            = r_out_valid;
    assign o_rsp.status           = r_o_status;
    assign o_rsp.removed_tag      = r_o_rem_tag;
    assign o_rsp.removed_priority = r_o_rem_prio;
    assign o_rsp.head_tag         = r_o_head_tag;
    assign o_rsp.head_priority    = r_o_head_prio;
    assign o_rsp.entry_count      = r_o_count;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count exceeds the queue depth");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status == ST_FULL) |-> (o_rsp.entry_count == CW'(DEPTH)))
        else $error("full status reported while the queue has room");

    a_empty_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status == ST_EMPTY) |->
            (o_rsp.entry_count == '0 && o_rsp.removed_tag == '0 &&
             o_rsp.removed_priority == '0))
        else $error("empty status reported with entries or a removed entry");

    a_empty_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_head_tag == '0 && r_head_prio == '0))
        else $error("head registers not cleared while the queue is empty");

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
    import spq_pkg::*;

    localparam int DEPTH  = 16;
    localparam int TAG_W  = 16;
    localparam int PRIO_W = 16;
    localparam int CNT_W  = 5;
    localparam int N_PHASES = 8;
    localparam int PHASE_ITEMS = 50;

    typedef struct {
        t_status           status;
        logic [TAG_W-1:0]  removed_tag;
        logic [PRIO_W-1:0] removed_priority;
        logic [TAG_W-1:0]  head_tag;
        logic [PRIO_W-1:0] head_priority;
        logic [CNT_W-1:0]  entry_count;
    } t_queue_result;

    class sorted_queue_scoreboard;
        logic [TAG_W-1:0]  slot_tag[DEPTH];
        logic [PRIO_W-1:0] slot_prio[DEPTH];
        int                fill;
        t_queue_result     expected_results[$];
        int                error_count;
        int                checked_count;

        function new();
            fill = 0;
            error_count = 0;
            checked_count = 0;
        endfunction

        function int outstanding();
            return expected_results.size();
        endfunction

        function void note_request(t_func func, logic [TAG_W-1:0] tag,
                                   logic [PRIO_W-1:0] prio);
            t_queue_result want;
            int pos;
            int i;
            want = '{ST_OK, '0, '0, '0, '0, '0};
            if (func == FN_ENQ) begin
                if (fill >= DEPTH) begin
                    want.status = ST_FULL;
                end else begin
                    pos = 0;
                    while (pos < fill && slot_prio[pos] <= prio) pos++;
                    for (i = fill; i > pos; i--) begin
                        slot_tag[i]  = slot_tag[i-1];
                        slot_prio[i] = slot_prio[i-1];
                    end
                    slot_tag[pos]  = tag;
                    slot_prio[pos] = prio;
                    fill++;
                end
            end else begin
                if (fill == 0) begin
                    want.status = ST_EMPTY;
                end else begin
                    want.removed_tag      = slot_tag[0];
                    want.removed_priority = slot_prio[0];
                    for (i = 1; i < fill; i++) begin
                        slot_tag[i-1]  = slot_tag[i];
                        slot_prio[i-1] = slot_prio[i];
                    end
                    fill--;
                end
            end
            if (fill > 0) begin
                want.head_tag      = slot_tag[0];
                want.head_priority = slot_prio[0];
            end
            want.entry_count = CNT_W'(fill);
            expected_results.push_back(want);
        endfunction

        task report_mismatch(string msg);
            $display("mismatch at response %0d: %s", checked_count, msg);
            error_count++;
        endtask

        task compare_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
        endtask

        task check_response(t_queue_result got);
            t_queue_result want;
            if (expected_results.size() == 0) begin
                report_mismatch("response arrived with no request outstanding");
            end else begin
                want = expected_results.pop_front();
                compare_field("status", 32'(got.status), 32'(want.status));
                compare_field("removed_tag", 32'(got.removed_tag),
                              32'(want.removed_tag));
                compare_field("removed_priority", 32'(got.removed_priority),
                              32'(want.removed_priority));
                compare_field("head_tag", 32'(got.head_tag), 32'(want.head_tag));
                compare_field("head_priority", 32'(got.head_priority),
                              32'(want.head_priority));
                compare_field("entry_count", 32'(got.entry_count),
                              32'(want.entry_count));
            end
            checked_count++;
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    spq_req_if #(.TAG_BITS(TAG_W), .PRIO_BITS(PRIO_W)) req_bus ();
    spq_rsp_if #(.TAG_BITS(TAG_W), .PRIO_BITS(PRIO_W), .CNT_BITS(CNT_W)) rsp_bus ();

    sorted_min_priority_queue_top #(
        .DEPTH(DEPTH),
        .PRIO_BITS(PRIO_W),
        .TAG_BITS(TAG_W)
    ) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_req(req_bus),
        .o_rsp(rsp_bus)
    );

    sorted_queue_scoreboard sb = new();

    bit tx_idle = 1'b1;
    bit rx_idle = 1'b1;
    int rx_hold_cycles = 0;

    always #10 i_clk = ~i_clk;

    function automatic int pick_gap(bit enabled);
        int r;
        if (!enabled) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [PRIO_W-1:0] pick_priority();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5) return PRIO_W'($urandom_range(0, 7));
        if (r < 8) return PRIO_W'($urandom);
        case ($urandom_range(0, 3))
            0: return '0;
            1: return '1;
            2: return 16'h7FFF;
            default: return 16'h8000;
        endcase
    endfunction

    // Called at a rising edge; returns at the edge where the transaction is accepted.
    task automatic send_request(t_func func, logic [TAG_W-1:0] tag,
                                logic [PRIO_W-1:0] prio);
        int gap;
        gap = pick_gap(tx_idle);
        if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_bus.valid         <= 1'b1;
        req_bus.func          <= func;
        req_bus.item_tag      <= tag;
        req_bus.item_priority <= prio;
        do @(posedge i_clk); while (!req_bus.ready);
        sb.note_request(func, tag, prio);
    endtask

    task automatic send_random(int enq_pct);
        t_func func;
        func = ($urandom_range(0, 99) < enq_pct) ? FN_ENQ : FN_DEQ;
        send_request(func, TAG_W'($urandom), pick_priority());
    endtask

    task automatic wait_drained();
        req_bus.valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
    endtask

    initial begin
        t_queue_result got;
        int stall_left;
        bit next_ready;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && rsp_bus.valid && rsp_bus.ready) begin
                got.status           = rsp_bus.status;
                got.removed_tag      = rsp_bus.removed_tag;
                got.removed_priority = rsp_bus.removed_priority;
                got.head_tag         = rsp_bus.head_tag;
                got.head_priority    = rsp_bus.head_priority;
                got.entry_count      = rsp_bus.entry_count;
                sb.check_response(got);
            end
            if (rx_hold_cycles > 0) begin
                rx_hold_cycles--;
                next_ready = 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                next_ready = 1'b0;
            end else begin
                if ($urandom_range(0, 2) == 0) stall_left = pick_gap(rx_idle);
                next_ready = (stall_left == 0);
            end
            rsp_bus.ready <= next_ready;
        end
    end

    logic [TAG_W-1:0] fill_tags[DEPTH] = '{
        16'hFFFF, 16'h0000, 16'hAAAA, 16'h5555, 16'h0001, 16'h1111, 16'h2222, 16'h3333,
        16'h4444, 16'h6666, 16'h7777, 16'h8888, 16'h9999, 16'hBBBB, 16'hCCCC, 16'hDDDD
    };
    logic [PRIO_W-1:0] fill_prios[DEPTH] = '{
        16'hFFFF, 16'h0000, 16'h8000, 16'h8000, 16'h8000, 16'h0001, 16'hFFFE, 16'h7FFF,
        16'h8000, 16'h0000, 16'hFFFF, 16'h0002, 16'h8001, 16'h3000, 16'hC000, 16'h0100
    };
    int enq_pcts[N_PHASES] = '{80, 50, 70, 20, 90, 10, 55, 45};

    initial begin
        int ph;
        int n;
        i_rst_n               <= 1'b0;
        req_bus.valid         <= 1'b0;
        req_bus.func          <= FN_ENQ;
        req_bus.item_tag      <= '0;
        req_bus.item_priority <= '0;
        rsp_bus.ready         <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_request(FN_DEQ, 16'h1234, 16'h0000);
        for (n = 0; n < DEPTH; n++) send_request(FN_ENQ, fill_tags[n], fill_prios[n]);
        send_request(FN_ENQ, 16'hEEEE, 16'h0000);
        for (n = 0; n < 5; n++) send_request(FN_DEQ, 16'hFFFF, 16'hFFFF);
        send_request(FN_ENQ, 16'hF00F, 16'h0000);

        for (ph = 0; ph < N_PHASES; ph++) begin
            tx_idle = (ph % 4 != 1) && (ph != 2);
            rx_idle = (ph % 4 != 3);
            if (ph == 2) rx_hold_cycles = 300;
            for (n = 0; n < PHASE_ITEMS; n++) send_random(enq_pcts[ph]);
            if (ph == 4) wait_drained();
        end

        wait_drained();
        repeat (40) @(posedge i_clk);
        if (sb.error_count == 0 && sb.outstanding() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #8000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
